// ===== design/dam_pkg.sv =====
// shared types, widths and codes of the adjacency matrix block
package dam_pkg;

  localparam int VERTEX_W         = 4;
  localparam int CFG_W            = 5;
  localparam int DEG_W            = 5;
  localparam int MAX_VERTICES_DEF = 16;
  localparam int VERTEX_LIMIT     = 2 ** VERTEX_W;
  localparam int QUEUE_DEPTH      = 2;

  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_TDATA_W = 16;

  localparam logic [CFG_W-1:0] VC_RESET = CFG_W'(16);

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REJECT = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] target;
  } cmd_t;

  typedef struct packed {
    logic                status;
    logic [VERTEX_W-1:0] neighbor;
    logic                neighbor_valid;
    logic [DEG_W-1:0]    in_degree;
    logic [DEG_W-1:0]    out_degree;
    logic                last;
  } res_t;

endpackage

// ===== design/dam_front.sv =====
// request intake: bounds check and classification into queue commands
module dam_front (
  input  logic                         in_valid,
  input  logic [1:0]                   req_type,
  input  logic [dam_pkg::VERTEX_W-1:0] vertex,
  input  logic [dam_pkg::VERTEX_W-1:0] target,
  input  logic [dam_pkg::CFG_W-1:0]    eff_count,
  input  logic                         q_full,
  output logic                         in_ready,
  output logic                         push,
  output dam_pkg::cmd_t                cmd
);
  import dam_pkg::*;

  logic v_ok;
  logic t_ok;
  logic known;

  assign v_ok     = {1'b0, vertex} < eff_count;
  assign t_ok     = {1'b0, target} < eff_count;
  assign in_ready = !q_full;

  always_comb begin
    cmd.vertex = vertex;
    cmd.target = target;
    cmd.op     = OP_REJECT;
    known      = 1'b1;
    case (req_type)
      REQ_ADD:   cmd.op = (v_ok && t_ok) ? OP_ADD : OP_REJECT;
      REQ_CLEAR: cmd.op = OP_CLEAR;
      REQ_QUERY: cmd.op = v_ok ? OP_QUERY : OP_REJECT;
      // unused request code is taken and dropped
      default:   known = 1'b0;
    endcase
  end

  assign push = in_valid && !q_full && known;

endmodule

// ===== design/dam_queue.sv =====
// short command queue between intake and execution
module dam_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dam_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          q_valid,
  output dam_pkg::cmd_t q_cmd
);
  import dam_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_cmd   = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/dam_back.sv =====
// command execution: arc matrix, degree counts and successor walk
module dam_back #(
  parameter int MAX_VERTICES = dam_pkg::MAX_VERTICES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dam_pkg::CFG_W-1:0] eff_count,
  input  logic                      q_valid,
  input  dam_pkg::cmd_t             q_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output dam_pkg::res_t             out_res
);
  import dam_pkg::*;

  // only indices that the vertex field can address are stored
  localparam int ROWS  = (MAX_VERTICES < VERTEX_LIMIT) ? MAX_VERTICES : VERTEX_LIMIT;
  localparam int IDX_W = $clog2(ROWS);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [ROWS-1:0]   mat_r [ROWS];
  logic [ROWS-1:0]   mat_nxt [ROWS];
  logic [IDX_W-1:0]  v_r, v_nxt;
  logic [ROWS-1:0]   row_r, row_nxt;
  logic [DEG_W-1:0]  indeg_r, indeg_nxt;
  logic [DEG_W-1:0]  outdeg_r, outdeg_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;

  logic              can_load;
  logic [ROWS-1:0]   mask;
  logic [ROWS-1:0]   col;
  logic [ROWS-1:0]   low_bit;
  logic [ROWS-1:0]   rest;
  logic [IDX_W-1:0]  low_idx;

  function automatic res_t ack(input logic status);
    res_t r;
    r        = '0;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

  assign can_load  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    for (int c = 0; c < ROWS; c++) begin
      mask[c] = c < int'(eff_count);
      col[c]  = mat_r[c][v_r] && mask[c];
    end
  end

  // lowest remaining successor
  assign low_bit = row_r & (~row_r + 1'b1);
  assign rest    = row_r & ~low_bit;

  always_comb begin
    low_idx = '0;
    for (int c = ROWS - 1; c >= 0; c--) begin
      if (row_r[c]) begin
        low_idx = IDX_W'(c);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    mat_nxt       = mat_r;
    v_nxt         = v_r;
    row_nxt       = row_r;
    indeg_nxt     = indeg_r;
    outdeg_nxt    = outdeg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && can_load) begin
          pop = 1'b1;
          case (q_cmd.op)
            OP_ADD: begin
              mat_nxt[q_cmd.vertex[IDX_W-1:0]][q_cmd.target[IDX_W-1:0]] = 1'b1;
              out_valid_nxt = 1'b1;
              res_nxt       = ack(1'b0);
            end
            OP_CLEAR: begin
              for (int c = 0; c < ROWS; c++) begin
                mat_nxt[c] = '0;
              end
              out_valid_nxt = 1'b1;
              res_nxt       = ack(1'b0);
            end
            OP_QUERY: begin
              v_nxt     = q_cmd.vertex[IDX_W-1:0];
              state_nxt = ST_CALC;
            end
            default: begin
              out_valid_nxt = 1'b1;
              res_nxt       = ack(1'b1);
            end
          endcase
        end
      end
      ST_CALC: begin
        row_nxt    = mat_r[v_r] & mask;
        outdeg_nxt = DEG_W'($countones(mat_r[v_r] & mask));
        indeg_nxt  = DEG_W'($countones(col));
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt      = 1'b1;
          res_nxt            = '0;
          res_nxt.in_degree  = indeg_r;
          res_nxt.out_degree = outdeg_r;
          if (row_r == '0) begin
            res_nxt.last = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            res_nxt.neighbor       = VERTEX_W'(low_idx);
            res_nxt.neighbor_valid = 1'b1;
            res_nxt.last           = rest == '0;
            row_nxt                = rest;
            if (rest == '0) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < ROWS; c++) begin
        mat_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mat_r       <= mat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    row_r    <= row_nxt;
    indeg_r  <= indeg_nxt;
    outdeg_r <= outdeg_nxt;
    res_r    <= res_nxt;
  end

endmodule

// ===== design/digraph_adjacency_matrix_core.sv =====
// directed graph adjacency matrix core: intake, command queue and execution
// add, clear and rejected requests: one transfer out, one per cycle while out_tready holds.
// query: ST_CALC fetches the row and counts degrees, then one result per cycle per successor
//   (one result if none) while not stalled; rate is set by the serial successor walk.
// intake runs ahead of execution by up to two queued commands.
// synchronous active-low reset clears the arc matrix and queue, vertex_count returns to 16.
module digraph_adjacency_matrix_core #(
  parameter int MAX_VERTICES = dam_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [dam_pkg::CFG_W-1:0]       cfg_wdata,   // vertex_count
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dam_pkg::IN_TUSER_W-1:0]  in_tuser,    // req_type
  input  logic [dam_pkg::IN_TDATA_W-1:0]  in_tdata,    // vertex, target
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dam_pkg::OUT_TUSER_W-1:0] out_tuser,   // status, neighbor_valid
  output logic [dam_pkg::OUT_TDATA_W-1:0] out_tdata,   // neighbor, in_degree, out_degree, zeros
  output logic                            out_tlast
);
  import dam_pkg::*;

  logic [CFG_W-1:0] vc_r;
  logic [CFG_W-1:0] eff_count;
  logic             push;
  cmd_t             push_cmd;
  logic             q_full;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             pop;
  res_t             res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= VC_RESET;
    end else if (cfg_we) begin
      vc_r <= cfg_wdata;
    end
  end

  assign eff_count = (int'(vc_r) > MAX_VERTICES) ? CFG_W'(MAX_VERTICES) : vc_r;

  dam_front u_front (
    .in_valid  (in_tvalid),
    .req_type  (in_tuser),
    .vertex    (in_tdata[VERTEX_W-1:0]),
    .target    (in_tdata[2*VERTEX_W-1:VERTEX_W]),
    .eff_count (eff_count),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .push      (push),
    .cmd       (push_cmd)
  );

  dam_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  dam_back #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_count (eff_count),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = {res.neighbor_valid, res.status};
  assign out_tdata = {2'b00, res.out_degree, res.in_degree, res.neighbor};
  assign out_tlast = res.last;

endmodule

// ===== tb/tb_digraph_adjacency_matrix_core.sv =====
// self-checking testbench for the directed graph adjacency matrix core
module tb_digraph_adjacency_matrix_core;
  timeunit 1ns;
  timeprecision 1ps;

  import dam_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;

  // tracks the arc matrix and queues the replies each request must cause
  class adjacency_tracker;
    logic [15:0]      rows [16];
    logic [CFG_W-1:0] vcount;
    res_t             expected_replies [$];
    int               errors;
    int               requests;
    int               replies_seen;

    function new();
      foreach (rows[i]) rows[i] = '0;
      vcount = VC_RESET;
      errors = 0;
      requests = 0;
      replies_seen = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] value);
      vcount = value;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void queue_reply(res_t r);
      expected_replies.insert(expected_replies.size(), r);
    endfunction

    function void note_request(logic [1:0] kind, logic [3:0] v, logic [3:0] w);
      int   n;
      int   indeg;
      int   outdeg;
      int   k;
      res_t r;
      n = (vcount > 16) ? 16 : int'(vcount);
      r = '0;
      r.last = 1'b1;
      requests++;
      case (kind)
        REQ_ADD: begin
          if (v >= n || w >= n) r.status = 1'b1;
          else rows[v][w] = 1'b1;
          queue_reply(r);
        end
        REQ_CLEAR: begin
          foreach (rows[i]) rows[i] = '0;
          queue_reply(r);
        end
        REQ_QUERY: begin
          if (v >= n) begin
            r.status = 1'b1;
            queue_reply(r);
          end else begin
            indeg = 0;
            outdeg = 0;
            // only rows and columns below the active count take part
            for (int c = 0; c < n; c++) begin
              if (rows[c][v]) indeg++;
              if (rows[v][c]) outdeg++;
            end
            r.in_degree = DEG_W'(indeg);
            r.out_degree = DEG_W'(outdeg);
            if (outdeg == 0) begin
              queue_reply(r);
            end else begin
              k = 0;
              for (int c = 0; c < n; c++) begin
                if (rows[v][c]) begin
                  r.neighbor = VERTEX_W'(c);
                  r.neighbor_valid = 1'b1;
                  r.last = (k == outdeg - 1);
                  queue_reply(r);
                  k++;
                end
              end
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(res_t got);
      res_t want;
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("reply with nothing outstanding: tuser/tdata fields %p", got);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("neighbor", want.neighbor, got.neighbor);
      compare_field("neighbor_valid", want.neighbor_valid, got.neighbor_valid);
      compare_field("in_degree", want.in_degree, got.in_degree);
      compare_field("out_degree", want.out_degree, got.out_degree);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;    // req_type
  logic [IN_TDATA_W-1:0]  in_tdata = '0;    // vertex, target
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TUSER_W-1:0] out_tuser;        // status, neighbor_valid
  logic [OUT_TDATA_W-1:0] out_tdata;        // neighbor, in_degree, out_degree, zeros
  logic                   out_tlast;

  adjacency_tracker tracker;
  bit               burst_mode = 1'b0;
  bit               long_hold = 1'b0;
  int               settings_used = 0;
  int               count_plan [8] = '{16, 1, 2, 7, 31, 0, 10, 16};

  digraph_adjacency_matrix_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("tb_digraph_adjacency_matrix_core NOT OK");
    $finish;
  end

  task automatic send_req(logic [1:0] kind, logic [3:0] v, logic [3:0] w);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {w, v};
    do @(posedge clk); while (!in_tready);
    tracker.note_request(kind, v, w);
  endtask

  // let everything drain, then settle for requests that give no reply
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_count(value);
    settings_used++;
    @(posedge clk);
  endtask

  task automatic rand_req(int n);
    int         r;
    bit         in_range;
    logic [1:0] kind;
    logic [3:0] v;
    logic [3:0] w;
    r = $urandom_range(0, 99);
    in_range = (n > 0) && ($urandom_range(0, 9) != 0);
    v = in_range ? 4'($urandom_range(0, n - 1)) : 4'($urandom_range(0, 15));
    in_range = (n > 0) && ($urandom_range(0, 9) != 0);
    w = in_range ? 4'($urandom_range(0, n - 1)) : 4'($urandom_range(0, 15));
    if (r < 55) kind = REQ_ADD;
    else if (r < 85) kind = REQ_QUERY;
    else if (r < 89) kind = REQ_CLEAR;
    else if (r < 95) kind = REQ_UNUSED;
    else kind = 2'($urandom_range(0, 3));
    send_req(kind, v, w);
  endtask

  // arcs from one vertex to every vertex below the count, itself included (or into it from all), then query it
  task automatic fill_star(int n, bit into);
    int         s;
    logic [3:0] hub;
    logic [3:0] other;
    s = $urandom_range(0, n - 1);
    hub = 4'($urandom_range(0, n - 1));
    for (int i = 0; i < n; i++) begin
      other = 4'((s + i) % n);
      if (into) send_req(REQ_ADD, other, hub);
      else send_req(REQ_ADD, hub, other);
    end
    send_req(REQ_QUERY, hub, 4'($urandom_range(0, 15)));
  endtask

  // result side: random stalls, one long hold-off when asked
  initial begin
    int   stall;
    res_t got;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = burst_mode ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = '0;
      got.status         = out_tuser[0];
      got.neighbor_valid = out_tuser[1];
      got.neighbor       = out_tdata[3:0];
      got.in_degree      = out_tdata[8:4];
      got.out_degree     = out_tdata[13:9];
      got.last           = out_tlast;
      tracker.check_reply(got);
    end
  end

  initial begin
    int n;
    tracker = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full count after reset: empty query, self loops, corner vertices
    send_req(REQ_QUERY, 4'd0, 4'd0);
    send_req(REQ_ADD, 4'd0, 4'd0);
    send_req(REQ_ADD, 4'd0, 4'd15);
    send_req(REQ_ADD, 4'd15, 4'd0);
    send_req(REQ_ADD, 4'd15, 4'd15);
    send_req(REQ_ADD, 4'd5, 4'd0);
    send_req(REQ_QUERY, 4'd0, 4'd9);
    send_req(REQ_QUERY, 4'd15, 4'd0);
    send_req(REQ_QUERY, 4'd7, 4'd0);
    send_req(REQ_UNUSED, 4'd15, 4'd15);

    // shrunk count: high arcs stay stored but are not seen
    wait_idle();
    write_count(5'd4);
    send_req(REQ_QUERY, 4'd0, 4'd0);
    send_req(REQ_QUERY, 4'd15, 4'd0);
    send_req(REQ_ADD, 4'd4, 4'd1);
    send_req(REQ_ADD, 4'd1, 4'd4);
    send_req(REQ_ADD, 4'd1, 4'd3);
    send_req(REQ_QUERY, 4'd3, 4'd0);
    send_req(REQ_CLEAR, 4'd0, 4'd0);
    send_req(REQ_QUERY, 4'd0, 4'd0);

    // zero count rejects all adds and queries, clear still works
    wait_idle();
    write_count(5'd0);
    send_req(REQ_ADD, 4'd0, 4'd0);
    send_req(REQ_QUERY, 4'd0, 4'd0);
    send_req(REQ_CLEAR, 4'd15, 4'd15);

    // count above the maximum acts as the maximum
    wait_idle();
    write_count(5'd31);
    send_req(REQ_ADD, 4'd15, 4'd15);
    send_req(REQ_QUERY, 4'd15, 4'd0);

    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_count(5'(count_plan[p]));
      n = (count_plan[p] > 16) ? 16 : count_plan[p];
      burst_mode = (p == 2 || p == 5);
      if (p == 3) long_hold = 1'b1;
      if ((p == 0 || p == 4) && n > 0) fill_star(n, 1'b0);
      for (int i = 0; i < 11; i++) rand_req(n);
      if (p == 7) fill_star(n, 1'b1);
    end
    burst_mode = 1'b0;

    in_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.pending() != 0) begin
      $error("%0d replies never arrived", tracker.pending());
      tracker.errors++;
    end

    $display("run covered %0d requests and %0d replies over %0d vertex_count settings",
             tracker.requests, tracker.replies_seen, settings_used);
    $display("counts 0, 1, 16 and 31 used, with a long output hold-off and full rows");
    if (tracker.errors == 0) begin
      $display("tb_digraph_adjacency_matrix_core OK");
    end else begin
      $display("tb_digraph_adjacency_matrix_core NOT OK");
    end
    $finish;
  end

endmodule
